// File: rtl/bprd_pkg.sv
// ----------------------------------------------------------------------------
// bprd_pkg: shared types and constants of the button pattern reset detector
// Beat payloads, configuration register set, switch state codes and the
// timing limits of the built-in press patterns.
// ----------------------------------------------------------------------------
package bprd_pkg;

  // Default sizing handed to the top level.
  localparam int NUM_SWITCHES_DEF  = 6;
  localparam int PATTERN_STEPS_DEF = 9;
  localparam int TIMER_BITS_DEF    = 16;

  // Pattern timing in milliseconds.
  localparam int SLOW_LO_MS       = 1000;
  localparam int SLOW_HI_FIRST_MS = 5000;
  localparam int SLOW_HI_MS       = 3000;
  localparam int FAST_HI_MS       = 500;
  localparam int FINAL_HOLD_MS    = 5000;

  // Only the first six switches have a bit in the pattern map.
  localparam logic [2:0] MAPPED_SWITCHES = 3'd6;

  // Step counter saturates at its all-ones value.
  localparam int STEP_W = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [9:0]  TICK_MS_RST         = 10'd10;
  localparam logic [15:0] RELEASE_HOLD_MS_RST = 16'd1000;
  localparam logic [5:0]  PATTERN_MAP_RST     = 6'd0;

  typedef enum logic [1:0] {
    REG_TICK_MS         = 2'd0,
    REG_RELEASE_HOLD_MS = 2'd1,
    REG_PATTERN_MAP     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    SW_RELEASED     = 2'd0,
    SW_PRE_PRESSED  = 2'd1,
    SW_PRESSED      = 2'd2,
    SW_PRE_RELEASED = 2'd3
  } sw_state_t;

  typedef struct packed {
    logic [9:0]  tick_ms;
    logic [15:0] release_hold_ms;
    logic [5:0]  pattern_map;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0] switch_index;
    logic [1:0] switch_state;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic             reset_fire;
    logic [1:0]       phase_now;
    logic [STEP_W-1:0] step_now;
  } out_item_t;

endpackage

// File: rtl/bprd_cfg.sv
// ----------------------------------------------------------------------------
// bprd_cfg: configuration register file
// Holds tick length, cooldown release hold and the per-switch pattern map,
// written and read over a simple peripheral bus.
// ----------------------------------------------------------------------------
module bprd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bprd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bprd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bprd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output bprd_pkg::cfg_regs_t             cfg
);
  import bprd_pkg::*;

  cfg_regs_t  cfg_r;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms         <= TICK_MS_RST;
      cfg_r.release_hold_ms <= RELEASE_HOLD_MS_RST;
      cfg_r.pattern_map     <= PATTERN_MAP_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TICK_MS:         cfg_r.tick_ms         <= pwdata[9:0];
        REG_RELEASE_HOLD_MS: cfg_r.release_hold_ms <= pwdata[15:0];
        REG_PATTERN_MAP:     cfg_r.pattern_map     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TICK_MS:         prdata = CFG_DATA_W'(cfg_r.tick_ms);
      REG_RELEASE_HOLD_MS: prdata = CFG_DATA_W'(cfg_r.release_hold_ms);
      REG_PATTERN_MAP:     prdata = CFG_DATA_W'(cfg_r.pattern_map);
      default:             prdata = '0;
    endcase
  end

endmodule

// File: rtl/bprd_core.sv
// ----------------------------------------------------------------------------
// bprd_core: per-switch pattern matcher
// Keeps phase, step, timer and check flag for every switch and computes the
// updated entry and the result of one tick in a single pass.
// ----------------------------------------------------------------------------
module bprd_core #(
  parameter int NUM_SWITCHES  = bprd_pkg::NUM_SWITCHES_DEF,
  parameter int PATTERN_STEPS = bprd_pkg::PATTERN_STEPS_DEF,
  parameter int TIMER_BITS    = bprd_pkg::TIMER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd_en,
  input  bprd_pkg::in_item_t  item,
  input  bprd_pkg::cfg_regs_t cfg,
  output bprd_pkg::out_item_t res
);
  import bprd_pkg::*;

  localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  localparam logic [TIMER_BITS-1:0] SLOW_LO_T       = TIMER_BITS'(SLOW_LO_MS);
  localparam logic [TIMER_BITS-1:0] SLOW_HI_FIRST_T = TIMER_BITS'(SLOW_HI_FIRST_MS);
  localparam logic [TIMER_BITS-1:0] SLOW_HI_T       = TIMER_BITS'(SLOW_HI_MS);
  localparam logic [TIMER_BITS-1:0] FAST_HI_T       = TIMER_BITS'(FAST_HI_MS);
  localparam logic [TIMER_BITS-1:0] FINAL_HOLD_T    = TIMER_BITS'(FINAL_HOLD_MS);
  localparam logic [STEP_W-1:0]     STEP_COUNT      = STEP_W'(PATTERN_STEPS);
  localparam logic [STEP_W-1:0]     LAST_STEP       = STEP_W'(PATTERN_STEPS - 1);
  localparam logic [3:0]            SWITCH_COUNT    = 4'(NUM_SWITCHES);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MATCH = 2'd1,
    PH_COOL  = 2'd2
  } phase_t;

  phase_t                  phase_r   [NUM_SWITCHES];
  logic [STEP_W-1:0]       step_r    [NUM_SWITCHES];
  logic [TIMER_BITS-1:0]   elapsed_r [NUM_SWITCHES];
  logic                    last_ok_r [NUM_SWITCHES];

  logic                    acc;
  logic [IDX_W-1:0]        idx;
  sw_state_t               sw;
  phase_t                  phase_rd;
  logic [STEP_W-1:0]       step_rd;
  logic [TIMER_BITS-1:0]   t_rd;
  logic                    ok_rd;
  phase_t                  phase_nxt;
  logic [STEP_W-1:0]       step_nxt;
  logic [TIMER_BITS-1:0]   t_nxt;
  logic                    ok_nxt;
  logic                    fire;
  logic                    fast;
  logic [TIMER_BITS:0]     t_sum;
  logic [TIMER_BITS-1:0]   t_add;
  logic [TIMER_BITS-1:0]   lo_t;
  logic [TIMER_BITS-1:0]   hi_t;
  sw_state_t               expect_sw;
  logic                    hold_done;

  assign acc      = ({1'b0, item.switch_index} < SWITCH_COUNT);
  assign idx      = item.switch_index[IDX_W-1:0];
  assign sw       = sw_state_t'(item.switch_state);
  assign phase_rd = phase_r[idx];
  assign step_rd  = step_r[idx];
  assign t_rd     = elapsed_r[idx];
  assign ok_rd    = last_ok_r[idx];

  // Saturating timer increment.
  assign t_sum = {1'b0, t_rd} + (TIMER_BITS + 1)'(cfg.tick_ms);
  assign t_add = t_sum[TIMER_BITS] ? '1 : t_sum[TIMER_BITS-1:0];

  // Switches beyond the map always follow the slow pattern.
  assign fast = (item.switch_index < MAPPED_SWITCHES) &&
                cfg.pattern_map[item.switch_index];
  assign lo_t = fast ? '0 : SLOW_LO_T;
  assign hi_t = fast ? FAST_HI_T : ((step_rd < 4'd2) ? SLOW_HI_FIRST_T : SLOW_HI_T);

  // Even steps expect a press, odd steps a release.
  assign expect_sw = step_rd[0] ? SW_RELEASED : SW_PRESSED;
  assign hold_done = (CMP_W'(t_rd) >= CMP_W'(cfg.release_hold_ms));

  always_comb begin
    phase_nxt = phase_rd;
    step_nxt  = step_rd;
    t_nxt     = t_rd;
    ok_nxt    = ok_rd;
    fire      = 1'b0;
    case (phase_rd)
      PH_IDLE: begin
        if (sw == SW_PRE_PRESSED) begin
          phase_nxt = PH_MATCH;
        end
      end
      PH_MATCH: begin
        if (sw == SW_PRESSED || sw == SW_RELEASED) begin
          if (step_rd >= STEP_COUNT) begin
            phase_nxt = PH_COOL;
          end else if (step_rd == LAST_STEP) begin
            if (sw != SW_PRESSED) begin
              phase_nxt = PH_COOL;
            end else if (t_rd < FINAL_HOLD_T) begin
              ok_nxt = 1'b0;
              t_nxt  = t_add;
            end else begin
              phase_nxt = PH_COOL;
              fire      = 1'b1;
            end
          end else if (sw != expect_sw) begin
            phase_nxt = PH_COOL;
          end else if (t_rd < lo_t) begin
            ok_nxt = 1'b0;
            t_nxt  = t_add;
          end else if (t_rd < hi_t) begin
            ok_nxt = 1'b1;
            t_nxt  = t_add;
          end else begin
            ok_nxt    = 1'b0;
            phase_nxt = PH_COOL;
          end
        end else if (ok_rd) begin
          // A stale flag keeps advancing the step on every transition beat.
          if (step_rd != '1) begin
            step_nxt = step_rd + 1'b1;
          end
          t_nxt = '0;
        end else begin
          phase_nxt = PH_COOL;
        end
      end
      PH_COOL: begin
        if (sw == SW_RELEASED) begin
          if (!hold_done) begin
            t_nxt = t_add;
          end else begin
            t_nxt     = '0;
            step_nxt  = '0;
            phase_nxt = PH_IDLE;
          end
        end else begin
          t_nxt = '0;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    res.accepted   = acc;
    res.reset_fire = acc && fire;
    res.phase_now  = acc ? 2'(phase_nxt) : 2'd0;
    res.step_now   = acc ? step_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        phase_r[i]   <= PH_IDLE;
        step_r[i]    <= '0;
        elapsed_r[i] <= '0;
        last_ok_r[i] <= 1'b0;
      end
    end else if (upd_en && acc) begin
      phase_r[idx]   <= phase_nxt;
      step_r[idx]    <= step_nxt;
      elapsed_r[idx] <= t_nxt;
      last_ok_r[idx] <= ok_nxt;
    end
  end

  a_fire_only_on_final_hold: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en && res.reset_fire |->
      phase_rd == PH_MATCH && step_rd == LAST_STEP && sw == SW_PRESSED)
    else $error("reset fired outside the final hold step");

  a_cool_exit_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en && acc && phase_rd == PH_COOL && phase_nxt == PH_IDLE |->
      sw == SW_RELEASED && step_nxt == '0 && t_nxt == '0)
    else $error("cooldown left without a steady release");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en && !acc |-> res == '0)
    else $error("rejected switch produced a non-zero result");

endmodule

// File: rtl/button_pattern_reset_detector.sv
// ----------------------------------------------------------------------------
// button_pattern_reset_detector: timed press pattern detector with reset fire
// Matches the press and release timing of up to eight switches against a slow
// or fast built-in pattern and flags the tick on which the final hold ends.
//
//   channel  direction  handshake                     payload
//   in       input      in_valid / in_stall           in_data   (in_item_t)
//   out      output     out_valid / out_stall         out_data  (out_item_t)
//   cfg      input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One beat is taken per cycle while in_stall is low; a result passes through
// the input register and then the result register.
// The per-switch entry is read, updated and written back in the cycle the
// beat leaves the input register, so consecutive beats for one switch chain.
// Reset clears every switch to idle and loads the register defaults.
// A stalled result holds the input register; further beats then see in_stall.
// ----------------------------------------------------------------------------
module button_pattern_reset_detector #(
  parameter int NUM_SWITCHES  = bprd_pkg::NUM_SWITCHES_DEF,
  parameter int PATTERN_STEPS = bprd_pkg::PATTERN_STEPS_DEF,
  parameter int TIMER_BITS    = bprd_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bprd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bprd_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bprd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bprd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bprd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bprd_pkg::*;

  cfg_regs_t cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t res;
  logic      out_free;
  logic      adv;
  logic      in_acc;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bprd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bprd_core #(
    .NUM_SWITCHES  (NUM_SWITCHES),
    .PATTERN_STEPS (PATTERN_STEPS),
    .TIMER_BITS    (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (adv),
    .item   (s1_item_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!s1_valid_r || out_free) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

endmodule
